>>> sv/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types and constants for the base-128 varint codec: item kinds,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
`default_nettype none

package vcc_pkg;

   // seven-bit groups, bit 7 marks a continuation byte
   localparam int GROUP_BITS = 7;
   localparam int MAX_BYTES  = 10;
   localparam int LEN_W      = 4;
   localparam int CNT_W      = 4;

   localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(MAX_BYTES);
   localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(MAX_BYTES - 1);

   // request function select
   typedef enum logic {
      FUNC_ENCODE = 1'b0,
      FUNC_DECODE = 1'b1
   } func_type;

   // result item kind
   typedef enum logic [1:0] {
      KIND_BYTE     = 2'd0,
      KIND_VALUE    = 2'd1,
      KIND_OVERFLOW = 2'd2
   } kind_type;

   // controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_ENC  = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic enc_first;   // take value, emit first encoded byte
      logic enc_next;    // emit next encoded byte from remainder
      logic dec_load;    // take one byte into the decoder
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic first_more;  // incoming value needs more than one byte
      logic rem_more;    // remainder needs more than one byte
      logic dec_cont;    // incoming byte has continuation bit
      logic dec_full;    // decoder already holds nine continuation bytes
   } stat_type;

endpackage

`default_nettype wire

>>> sv/vcc_ctrl.sv
// ----------------------------------------------------------------------------
// vcc_ctrl
// Controller: handshakes on both channels, sequences the bytes of an encode
// and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module vcc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic              req_func,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output vcc_pkg::cmd_type       cmd,
   input  wire vcc_pkg::stat_type stat
);

   vcc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;
   logic               produce;

   // output slot can take a new item when empty or being drained
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == vcc_pkg::ST_IDLE) && slot_free;
   assign rsp_tvalid = rsp_valid_ff;

   // state register and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vcc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      produce   = 1'b0;
      case (state_ff)
         vcc_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_func == vcc_pkg::FUNC_ENCODE) begin
                  cmd.enc_first = 1'b1;
                  produce       = 1'b1;
                  if (stat.first_more) begin
                     state_in = vcc_pkg::ST_ENC;
                  end
               end else begin
                  cmd.dec_load = 1'b1;
                  // a continuation byte short of the limit gives nothing
                  produce      = !stat.dec_cont || stat.dec_full;
               end
            end
         end
         vcc_pkg::ST_ENC: begin
            if (slot_free) begin
               cmd.enc_next = 1'b1;
               produce      = 1'b1;
               if (!stat.rem_more) begin
                  state_in = vcc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = vcc_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = produce ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

endmodule

`default_nettype wire

>>> sv/vcc_dp.sv
// ----------------------------------------------------------------------------
// vcc_dp
// Datapath: encode remainder shifter, decode accumulator and byte count,
// and the result item register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcc_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire vcc_pkg::cmd_type               cmd,
   output vcc_pkg::stat_type                   stat,
   input  wire logic [63:0]                    value_in,
   input  wire logic [7:0]                     byte_in,
   output vcc_pkg::kind_type                   kind,
   output logic [7:0]                          byte_out,
   output logic [63:0]                         value_out,
   output logic [vcc_pkg::LEN_W-1:0]           length,
   output logic                                last
);

   localparam int REM_W = 64 - vcc_pkg::GROUP_BITS;

   // encode state
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [vcc_pkg::CNT_W-1:0]   enc_cnt_ff, enc_cnt_in;
   // decode state
   logic [63:0]                 acc_ff, acc_in;
   logic [vcc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   // result register
   vcc_pkg::kind_type           kind_ff, kind_in;
   logic [7:0]                  byte_ff, byte_in_r;
   logic [63:0]                 value_ff, value_in_r;
   logic [vcc_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                        last_ff, last_in;
   logic                        out_load;

   logic [5:0]                  shamt;
   logic [63:0]                 shifted;
   logic [63:0]                 acc_new;
   logic [vcc_pkg::CNT_W-1:0]   cnt_inc;
   logic [vcc_pkg::CNT_W-1:0]   enc_cnt_inc;

   // status to the controller
   assign stat.first_more = |value_in[63:vcc_pkg::GROUP_BITS];
   assign stat.rem_more   = |rem_ff[REM_W-1:vcc_pkg::GROUP_BITS];
   assign stat.dec_cont   = byte_in[7];
   assign stat.dec_full   = (cnt_ff == vcc_pkg::CNT_LAST);

   // group position of the incoming decode byte
   always_comb begin
      case (cnt_ff)
         4'd0:    shamt = 6'd0;
         4'd1:    shamt = 6'd7;
         4'd2:    shamt = 6'd14;
         4'd3:    shamt = 6'd21;
         4'd4:    shamt = 6'd28;
         4'd5:    shamt = 6'd35;
         4'd6:    shamt = 6'd42;
         4'd7:    shamt = 6'd49;
         4'd8:    shamt = 6'd56;
         4'd9:    shamt = 6'd63;
         default: shamt = 6'd0;
      endcase
   end

   // bits pushed past bit 63 fall off
   assign shifted     = {57'd0, byte_in[6:0]} << shamt;
   assign acc_new     = acc_ff | shifted;
   assign cnt_inc     = cnt_ff + 1'b1;
   assign enc_cnt_inc = enc_cnt_ff + 1'b1;
   assign out_load    = cmd.enc_first || cmd.enc_next || cmd.dec_load;

   // next values
   always_comb begin
      rem_in     = rem_ff;
      enc_cnt_in = enc_cnt_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      kind_in    = vcc_pkg::KIND_BYTE;
      byte_in_r  = 8'd0;
      value_in_r = 64'd0;
      len_in     = '0;
      last_in    = 1'b0;

      if (cmd.enc_first) begin
         byte_in_r  = {stat.first_more, value_in[6:0]};
         len_in     = stat.first_more ? '0 : vcc_pkg::LEN_W'(1);
         last_in    = !stat.first_more;
         rem_in     = value_in[63:vcc_pkg::GROUP_BITS];
         enc_cnt_in = vcc_pkg::CNT_W'(1);
      end else if (cmd.enc_next) begin
         byte_in_r  = {stat.rem_more, rem_ff[6:0]};
         len_in     = stat.rem_more ? '0 : enc_cnt_inc;
         last_in    = !stat.rem_more;
         rem_in     = rem_ff >> vcc_pkg::GROUP_BITS;
         enc_cnt_in = enc_cnt_inc;
      end else if (cmd.dec_load) begin
         last_in = 1'b1;
         if (!byte_in[7]) begin
            // terminating byte ends the value
            kind_in    = vcc_pkg::KIND_VALUE;
            value_in_r = acc_new;
            len_in     = cnt_inc;
            acc_in     = 64'd0;
            cnt_in     = '0;
         end else if (stat.dec_full) begin
            // tenth continuation byte
            kind_in = vcc_pkg::KIND_OVERFLOW;
            len_in  = vcc_pkg::LEN_MAX;
            acc_in  = 64'd0;
            cnt_in  = '0;
         end else begin
            acc_in = acc_new;
            cnt_in = cnt_inc;
         end
      end
   end

   // decode state carries across request bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 64'd0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   // encode remainder and result payload
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      enc_cnt_ff <= enc_cnt_in;
      if (out_load) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in_r;
         value_ff <= value_in_r;
         len_ff   <= len_in;
         last_ff  <= last_in;
      end
   end

   assign kind      = kind_ff;
   assign byte_out  = byte_ff;
   assign value_out = value_ff;
   assign length    = len_ff;
   assign last      = last_ff;

endmodule

`default_nettype wire

>>> sv/varint_codec_unit.sv
// ----------------------------------------------------------------------------
// varint_codec_unit
// Unsigned 64-bit base-128 varint encoder and streaming decoder.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                               | tuser   | tlast
//  req_    | in  | value_in[63:0] byte_in[71:64]       | func    | -
//  rsp_    | out | byte_out[7:0] value_out[71:8]       | kind    | last
//          |     | length[75:72] zero[79:76]           |         |
//
//  Decode takes one byte per cycle; a byte that ends a value or hits the
//  ten-byte limit yields one item. Encode yields an n-byte encoding (1..10):
//  the remainder shifter emits one byte per cycle while the result register
//  is free, and no new item is taken until the last byte is loaded into it.
//  Reset clears the decode accumulator, its byte count and the result valid.
//  A stalled result holds its register and blocks further output; input is
//  taken only between encodes, with the result register empty or draining.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_codec_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // value_in[63:0], byte_in[71:64]
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // byte_out[7:0], value_out[71:8], length[75:72]
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast    // last
);

   vcc_pkg::cmd_type             cmd;
   vcc_pkg::stat_type            stat;
   vcc_pkg::kind_type            kind;
   logic [7:0]                   byte_out;
   logic [63:0]                  value_out;
   logic [vcc_pkg::LEN_W-1:0]    length;

   vcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   vcc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .value_in  (req_tdata[63:0]),
      .byte_in   (req_tdata[71:64]),
      .kind      (kind),
      .byte_out  (byte_out),
      .value_out (value_out),
      .length    (length),
      .last      (rsp_tlast)
   );

   // pack the result item
   assign rsp_tdata = {4'd0, length, value_out, byte_out};
   assign rsp_tuser = kind;

endmodule

`default_nettype wire
